[src/mmfr_pkg.sv]
// shared types and constants of the midi message filter and router
package mmfr_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_MSG   = 2'd0,
    KIND_MAP   = 2'd1,
    KIND_UNMAP = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FILTER_MASK = 3'd0,
    CFG_CHMAP_LO    = 3'd1,
    CFG_CHMAP_HI    = 3'd2,
    CFG_PRESENT     = 3'd3,
    CFG_MASKS_01    = 3'd4,
    CFG_MASKS_23    = 3'd5
  } cfg_idx_e;

  localparam int unsigned CFG_WIDTH   = 40;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned MASK_W      = 17;
  localparam int unsigned TAB_DEPTH   = 128;
  localparam int unsigned QUEUE_DEPTH = 4;

  // status high nibbles
  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_POLY_AT   = 4'hA;
  localparam logic [3:0] HI_CTRL      = 4'hB;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PITCH     = 4'hE;
  localparam logic [3:0] HI_SYSTEM    = 4'hF;
  localparam logic [7:0] STATUS_SYSEX = 8'hF0;

  // filter class bit positions
  localparam int unsigned CLS_NOTE_ON  = 0;
  localparam int unsigned CLS_NOTE_OFF = 1;
  localparam int unsigned CLS_CTRL     = 2;
  localparam int unsigned CLS_PROGRAM  = 3;
  localparam int unsigned CLS_PITCH    = 4;
  localparam int unsigned CLS_POLY_AT  = 5;
  localparam int unsigned CLS_SYSEX    = 6;

  // configuration register file seen by the front end
  typedef struct packed {
    logic [6:0]  filter_mask;
    logic [39:0] chmap_lo;
    logic [39:0] chmap_hi;
    logic [3:0]  present;
    logic [33:0] masks_01;
    logic [33:0] masks_23;
  } cfg_t;

  // controller remap table entry, valid bit kept apart
  typedef struct packed {
    logic [6:0] cc;
    logic [4:0] ch;
  } tab_t;

  // routed message as it travels to the back end
  typedef struct packed {
    logic [7:0]  status;
    logic [6:0]  data1;
    logic [6:0]  data2;
    logic [15:0] timestamp;
  } msg_t;

endpackage

[src/mmfr_ram.sv]
// generic single port ram with registered read
module mmfr_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read first port, read data held until next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/mmfr_fifo.sv]
// short queue between the classifying front end and the fan-out back end
module mmfr_fifo #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // fill count stays within the depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  // pointers agree with the fill count when empty
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers differ while empty");

endmodule

[src/mmfr_front.sv]
// front end: accepts items, keeps the controller table, filters and remaps messages
module mmfr_front #(
  parameter int unsigned NUM_OUTPUTS = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mmfr_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             kind_i,
  input  logic [7:0]             status_i,
  input  logic [6:0]             data1_i,
  input  logic [6:0]             data2_i,
  input  logic [15:0]            timestamp_i,
  input  logic [6:0]             map_input_cc_i,
  input  logic [6:0]             map_output_cc_i,
  input  logic [4:0]             map_channel_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output mmfr_pkg::msg_t         out_msg_o,
  output logic [NUM_OUTPUTS-1:0] out_dest_o
);
  import mmfr_pkg::*;

  localparam int unsigned TAW = $clog2(TAB_DEPTH);

  kind_e             in_kind;
  logic              acc;
  logic [TAW-1:0]    tab_addr;
  tab_t              tab_wdata, tab_rdata;
  logic [TAB_DEPTH-1:0] valid_q, valid_d;

  // stage one registers
  logic              s1_valid_q;
  kind_e             s1_kind_q;
  logic [7:0]        s1_status_q;
  logic [6:0]        s1_d1_q, s1_d2_q;
  logic [15:0]       s1_ts_q;
  logic [6:0]        s1_icc_q;
  logic [4:0]        s1_mch_q;
  logic              s1_vs_q;

  logic              s1_go, unmap_clr, is_msg, drop, kept;
  logic [3:0]        hi;
  logic [6:0]        cls;
  logic [4:0]        ch, tgt;
  logic [3:0]        nc;
  logic [39:0]       map_reg;
  logic [7:0]        st_new;
  logic [6:0]        d1_new;
  logic [MASK_W-1:0] omask;

  assign in_kind = kind_e'(kind_i);
  assign acc     = in_valid_i && in_ready_o;

  // table data lives in ram, read for messages and unmaps at accept
  assign tab_addr  = (in_kind == KIND_MSG) ? data1_i : map_input_cc_i;
  assign tab_wdata = '{cc: map_output_cc_i, ch: map_channel_i};

  mmfr_ram #(
    .WIDTH ($bits(tab_t)),
    .DEPTH (TAB_DEPTH)
  ) u_tab (
    .clk_i   (clk_i),
    .we_i    (acc && (in_kind == KIND_MAP)),
    .re_i    (acc && ((in_kind == KIND_MSG) || (in_kind == KIND_UNMAP))),
    .addr_i  (tab_addr),
    .wdata_i (tab_wdata),
    .rdata_o (tab_rdata)
  );

  // unmap resolves in the cycle after accept, once the entry channel is read
  assign unmap_clr = s1_valid_q && (s1_kind_q == KIND_UNMAP) && s1_vs_q &&
                     ((s1_mch_q == '0) || (tab_rdata.ch == s1_mch_q));

  // valid bits: older unmap first, then the item accepted now
  always_comb begin
    valid_d = valid_q;
    if (unmap_clr) begin
      valid_d[s1_icc_q] = 1'b0;
    end
    if (acc) begin
      case (in_kind)
        KIND_MAP:   valid_d[map_input_cc_i] = 1'b1;
        KIND_CLEAR: valid_d = '0;
        default:    ;
      endcase
    end
  end

  // message classification and filter
  assign hi     = s1_status_q[7:4];
  assign is_msg = (s1_kind_q == KIND_MSG);

  always_comb begin
    cls = '0;
    cls[CLS_NOTE_ON]  = (hi == HI_NOTE_ON) && (s1_d2_q != '0);
    cls[CLS_NOTE_OFF] = (hi == HI_NOTE_OFF) || ((hi == HI_NOTE_ON) && (s1_d2_q == '0));
    cls[CLS_CTRL]     = (hi == HI_CTRL);
    cls[CLS_PROGRAM]  = (hi == HI_PROGRAM);
    cls[CLS_PITCH]    = (hi == HI_PITCH);
    cls[CLS_POLY_AT]  = (hi == HI_POLY_AT);
    cls[CLS_SYSEX]    = (s1_status_q == STATUS_SYSEX);
  end

  assign drop = |(cls & cfg_i.filter_mask);
  assign kept = is_msg && !drop;

  // channel remap, system messages keep channel zero
  assign map_reg = s1_status_q[3] ? cfg_i.chmap_hi : cfg_i.chmap_lo;

  always_comb begin
    tgt = '0;
    for (int j = 0; j < 8; j++) begin
      if (s1_status_q[2:0] == 3'(j)) begin
        tgt = map_reg[j*5 +: 5];
      end
    end
    nc     = 4'(tgt - 5'd1);
    st_new = s1_status_q;
    ch     = '0;
    if (hi != HI_SYSTEM) begin
      ch = {1'b0, s1_status_q[3:0]} + 5'd1;
      if (tgt != '0) begin
        st_new = {hi, nc};
        ch     = {1'b0, nc} + 5'd1;
      end
    end
  end

  // controller remap from the table
  always_comb begin
    d1_new = s1_d1_q;
    if ((hi == HI_CTRL) && s1_vs_q && ((tab_rdata.ch == '0) || (tab_rdata.ch == ch))) begin
      d1_new = tab_rdata.cc;
    end
  end

  // destination mask over present outputs
  always_comb begin
    out_dest_o = '0;
    omask      = '0;
    for (int i = 0; i < NUM_OUTPUTS; i++) begin
      omask = (i < 2) ? cfg_i.masks_01[(i & 1) * MASK_W +: MASK_W]
                      : cfg_i.masks_23[(i & 1) * MASK_W +: MASK_W];
      out_dest_o[i] = cfg_i.present[i] && omask[ch];
    end
  end

  assign out_msg_o   = '{status: st_new, data1: d1_new, data2: s1_d2_q, timestamp: s1_ts_q};
  assign out_valid_o = s1_valid_q && kept;
  assign s1_go       = s1_valid_q && (!kept || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_go;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      valid_q    <= '0;
    end else begin
      valid_q <= valid_d;
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_kind_q   <= in_kind;
      s1_status_q <= status_i;
      s1_d1_q     <= data1_i;
      s1_d2_q     <= data2_i;
      s1_ts_q     <= timestamp_i;
      s1_icc_q    <= map_input_cc_i;
      s1_mch_q    <= map_channel_i;
      s1_vs_q     <= valid_d[tab_addr];
    end
  end

  // a stalled message keeps its stage one contents
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> (s1_valid_q && $stable(s1_status_q) && $stable(s1_d1_q)))
    else $error("stage one changed while stalled");

endmodule

[src/mmfr_back.sv]
// back end: fans one queued message out to its destinations, one transaction a cycle while the output is not stalled
module mmfr_back #(
  parameter int unsigned NUM_OUTPUTS = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  mmfr_pkg::msg_t         in_msg_i,
  input  logic [NUM_OUTPUTS-1:0] in_dest_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             destination_o,
  output logic [7:0]             out_status_o,
  output logic [6:0]             out_data1_o,
  output logic [6:0]             out_data2_o,
  output logic [15:0]            out_timestamp_o,
  output logic                   last_o
);
  import mmfr_pkg::*;

  logic                   cur_valid_q;
  msg_t                   cur_msg_q;
  logic [NUM_OUTPUTS-1:0] cur_rem_q;
  logic [NUM_OUTPUTS-1:0] pick;
  logic [2:0]             dest;
  logic                   is_last, load_out, pop;

  logic                   out_valid_q;
  msg_t                   out_msg_q;
  logic [2:0]             out_dest_q;
  logic                   out_last_q;

  // lowest remaining destination, main output when none
  always_comb begin
    pick = '0;
    dest = '0;
    for (int i = NUM_OUTPUTS - 1; i >= 0; i--) begin
      if (cur_rem_q[i]) begin
        pick    = '0;
        pick[i] = 1'b1;
        dest    = 3'(i + 1);
      end
    end
    is_last = ((cur_rem_q & ~pick) == '0);
  end

  assign load_out   = cur_valid_q && (!out_valid_q || out_ready_i);
  assign pop        = in_valid_i && (!cur_valid_q || (load_out && is_last));
  assign in_ready_o = !cur_valid_q || (load_out && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_q <= 1'b1;
      end else if (load_out && is_last) begin
        cur_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // current message and output register payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_msg_q <= in_msg_i;
      cur_rem_q <= in_dest_i;
    end else if (load_out) begin
      cur_rem_q <= cur_rem_q & ~pick;
    end
    if (load_out) begin
      out_msg_q  <= cur_msg_q;
      out_dest_q <= dest;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign destination_o   = out_dest_q;
  assign out_status_o    = out_msg_q.status;
  assign out_data1_o     = out_msg_q.data1;
  assign out_data2_o     = out_msg_q.data2;
  assign out_timestamp_o = out_msg_q.timestamp;
  assign last_o          = out_last_q;

  // main output only ever carries a single transaction
  a_main_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_dest_q == '0)) |-> out_last_q)
    else $error("main output transaction not marked last");

  // destinations stay within the configured outputs
  a_dest_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_dest_q <= 3'(NUM_OUTPUTS)))
    else $error("destination beyond output count");

endmodule

[src/midi_message_filter_router_top.sv]
// top level of the midi message filter and router
//
// Input channel (in_valid_i/in_ready_o): one item per transaction, either a
// complete midi message (kind 0) or a controller table update (map, unmap,
// clear). Output channel (out_valid_o/out_ready_i): one transaction per
// destination of a kept message, last_o set on the final one; a message that
// no present output admits goes once to the main output (destination 0).
// Filtered messages and table updates produce no output transaction.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i at the
// clock edge; the user must write only while the block is idle, which the
// block itself does not enforce. Path: an accepted message passes stage one,
// the queue, the fan-out register and the output register, in that order.
// Throughput: one item per cycle while the queue has room; a message fanned
// out to k outputs holds the back end for k transactions, so the sustained
// rate is set by the one-transaction-per-cycle fan-out stage.
// Reset: all controller table entries invalid, registers at their defaults.
// Output stall: the output register holds; a four-entry queue lets the front
// end keep taking items until it fills, then a kept message waits in stage
// one and the input stalls, table updates included.
module midi_message_filter_router_top #(
  parameter int unsigned NUM_OUTPUTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [39:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  status_i,
  input  logic [6:0]  data1_i,
  input  logic [6:0]  data2_i,
  input  logic [15:0] timestamp_i,
  input  logic [6:0]  map_input_cc_i,
  input  logic [6:0]  map_output_cc_i,
  input  logic [4:0]  map_channel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  destination_o,
  output logic [7:0]  out_status_o,
  output logic [6:0]  out_data1_o,
  output logic [6:0]  out_data2_o,
  output logic [15:0] out_timestamp_o,
  output logic        last_o
);
  import mmfr_pkg::*;

  localparam int unsigned QW = $bits(msg_t) + NUM_OUTPUTS;

  cfg_t                   cfg_q;
  logic                   f_valid, f_ready;
  msg_t                   f_msg;
  logic [NUM_OUTPUTS-1:0] f_dest;
  logic                   b_valid, b_ready;
  logic [QW-1:0]          q_rdata;
  msg_t                   b_msg;
  logic [NUM_OUTPUTS-1:0] b_dest;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_mask <= '0;
      cfg_q.chmap_lo    <= '0;
      cfg_q.chmap_hi    <= '0;
      cfg_q.present     <= '0;
      cfg_q.masks_01    <= '1;
      cfg_q.masks_23    <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_FILTER_MASK: cfg_q.filter_mask <= cfg_wdata_i[6:0];
        CFG_CHMAP_LO:    cfg_q.chmap_lo    <= cfg_wdata_i;
        CFG_CHMAP_HI:    cfg_q.chmap_hi    <= cfg_wdata_i;
        CFG_PRESENT:     cfg_q.present     <= cfg_wdata_i[3:0];
        CFG_MASKS_01:    cfg_q.masks_01    <= cfg_wdata_i[33:0];
        CFG_MASKS_23:    cfg_q.masks_23    <= cfg_wdata_i[33:0];
        default:         ;
      endcase
    end
  end

  // classify and remap
  mmfr_front #(
    .NUM_OUTPUTS (NUM_OUTPUTS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .status_i        (status_i),
    .data1_i         (data1_i),
    .data2_i         (data2_i),
    .timestamp_i     (timestamp_i),
    .map_input_cc_i  (map_input_cc_i),
    .map_output_cc_i (map_output_cc_i),
    .map_channel_i   (map_channel_i),
    .out_valid_o     (f_valid),
    .out_ready_i     (f_ready),
    .out_msg_o       (f_msg),
    .out_dest_o      (f_dest)
  );

  // decoupling queue
  mmfr_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_dest, f_msg}),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_rdata)
  );

  assign b_msg  = msg_t'(q_rdata[$bits(msg_t)-1:0]);
  assign b_dest = q_rdata[QW-1 -: NUM_OUTPUTS];

  // fan-out
  mmfr_back #(
    .NUM_OUTPUTS (NUM_OUTPUTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (b_valid),
    .in_ready_o      (b_ready),
    .in_msg_i        (b_msg),
    .in_dest_i       (b_dest),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .destination_o   (destination_o),
    .out_status_o    (out_status_o),
    .out_data1_o     (out_data1_o),
    .out_data2_o     (out_data2_o),
    .out_timestamp_o (out_timestamp_o),
    .last_o          (last_o)
  );

endmodule
